// ===== hw/rtl/msbb_pkg.sv =====
// msbb_pkg: shared codes and constants of the MSB-first bit buffer.
// No dependencies; used by msb_first_bit_buffer_unit.
package msbb_pkg;

    // operation codes carried in the mode field
    localparam logic [2:0] MODE_PUT  = 3'd0;
    localparam logic [2:0] MODE_GET  = 3'd1;
    localparam logic [2:0] MODE_SHOW = 3'd2;
    localparam logic [2:0] MODE_SKIP = 3'd3;
    localparam logic [2:0] MODE_SET  = 3'd4;

    // widest field moved by put, get or show
    localparam int MAX_FIELD_BITS = 32;

    // byte window covering the widest field at any bit offset (five bytes)
    localparam int WIN_BYTES = 5;
    localparam int WIN_BITS  = 8 * WIN_BYTES;

    // configuration register index
    localparam logic REG_SIZE_BYTES = 1'b0;

endpackage

// ===== hw/rtl/msb_first_bit_buffer_unit.sv =====
// msb_first_bit_buffer_unit: MSB-first bit buffer over a byte RAM, APB size register.
// Put/get/show spanning n bytes (1..5) visit each byte in ST_MOD, then register their
// result in ST_OUT; skip, set, refused and zero-width items go straight to ST_OUT.
// The RAM is read byte by byte, merged and written back for put, one word at a time.
// Reset: asynchronous, active low; a clearing pass then zeroes the RAM byte by byte,
// during which input words are stalled (configuration writes are taken).
// Depends on msbb_pkg and msbb_ram.
module msb_first_bit_buffer_unit #(
    parameter int STORE_BYTES = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    // input channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  mode,
    input  logic [11:0] bit_count,
    input  logic [31:0] put_value,
    input  logic [11:0] new_position,
    // output channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] read_value,
    output logic [11:0] position,
    output logic [11:0] remaining_bits,
    output logic        error,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW = $clog2(STORE_BYTES);
    localparam int WB = msbb_pkg::WIN_BITS;
    localparam logic [8:0] STORE_CLAMP = (STORE_BYTES > 511) ? 9'd511 : 9'(STORE_BYTES);
    localparam logic [AW-1:0] LAST_ADDR = AW'(STORE_BYTES - 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MOD  = 2'd1;
    localparam logic [1:0] ST_OUT  = 2'd2;

    // control state
    logic [1:0]    state_reg, state_next;
    logic          clearing_reg;
    logic [AW-1:0] clr_cnt_reg;
    logic [8:0]    size_reg;
    logic [11:0]   pos_reg, pos_next;
    logic          out_valid_reg, out_valid_next;
    logic [2:0]    bytes_left_reg, bytes_left_next;

    // item payload
    logic [2:0]    mode_reg;
    logic [11:0]   count_reg;
    logic [11:0]   npos_reg;
    logic          err_reg;
    logic          access_reg;
    logic [2:0]    tail_reg;
    logic [WB-1:0] put_win_reg, put_win_next;
    logic [WB-1:0] acc_reg, acc_next;
    logic [AW-1:0] cur_addr_reg, cur_addr_next;

    // result payload
    logic [31:0]   rv_reg;
    logic [11:0]   res_pos_reg;
    logic [11:0]   rem_reg;
    logic          res_err_reg;

    // RAM ports
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [7:0]    mem_wdata;
    logic [AW-1:0] mem_raddr;
    logic [7:0]    mem_rdata;

    // accept-side decode
    logic [8:0]    lim_bytes;
    logic [11:0]   limit_bits;
    logic          in_accept;
    logic          out_take;
    logic          is_rw;
    logic          err_acc;
    logic          access_acc;
    logic [5:0]    span;
    logic [2:0]    nb_acc;
    logic [2:0]    tail_acc;
    logic [32:0]   mask_acc;
    logic [31:0]   pval_m;
    logic [WB-1:0] win1;
    logic [WB-1:0] win_acc;
    logic [AW-1:0] first_addr;

    // result-side decode
    logic [32:0]   mask_out;
    logic [WB-1:0] acc_sh;
    logic [31:0]   rv_out;
    logic [11:0]   rem_out;
    logic          out_load;

    msbb_ram #(
        .WIDTH (8),
        .DEPTH (STORE_BYTES)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // configured limit in bits
    assign lim_bytes  = (size_reg > STORE_CLAMP) ? STORE_CLAMP : size_reg;
    assign limit_bits = {lim_bytes, 3'b000};

    // handshakes
    assign in_stall  = (state_reg != ST_IDLE) || clearing_reg;
    assign in_accept = in_valid && !in_stall;
    assign out_take  = out_valid_reg && !out_stall;
    assign pready    = 1'b1;

    // configuration read
    always_comb
    begin
        prdata = 32'd0;
        if (paddr[2] == msbb_pkg::REG_SIZE_BYTES)
        begin
            prdata = {23'd0, size_reg};
        end
    end

    // decode of an incoming word: refusal, byte span, put window
    always_comb
    begin
        is_rw = (mode == msbb_pkg::MODE_PUT) || (mode == msbb_pkg::MODE_GET) ||
                (mode == msbb_pkg::MODE_SHOW);
        if (is_rw)
        begin
            err_acc = (bit_count > 12'(msbb_pkg::MAX_FIELD_BITS)) ||
                      (pos_reg > limit_bits) || (bit_count > (limit_bits - pos_reg));
        end
        else
        begin
            err_acc = (mode != msbb_pkg::MODE_SKIP) && (mode != msbb_pkg::MODE_SET);
        end
        access_acc = is_rw && !err_acc && (bit_count != 12'd0);

        span     = {3'd0, pos_reg[2:0]} + bit_count[5:0] - 6'd1;
        nb_acc   = span[5:3] + 3'd1;
        tail_acc = 3'd7 - span[2:0];
        mask_acc = (33'd1 << bit_count[5:0]) - 33'd1;
        pval_m   = put_value & mask_acc[31:0];
        win1     = {8'd0, pval_m} << tail_acc;
        case (nb_acc)
            3'd1:    win_acc = win1 << 32;
            3'd2:    win_acc = win1 << 24;
            3'd3:    win_acc = win1 << 16;
            3'd4:    win_acc = win1 << 8;
            default: win_acc = win1;
        endcase
        first_addr = AW'(pos_reg >> 3);
    end

    // result decode
    always_comb
    begin
        mask_out = (33'd1 << count_reg[5:0]) - 33'd1;
        acc_sh   = acc_reg >> tail_reg;
        if (access_reg && (mode_reg != msbb_pkg::MODE_PUT))
        begin
            rv_out = acc_sh[31:0] & mask_out[31:0];
        end
        else
        begin
            rv_out = 32'd0;
        end

        pos_next = pos_reg;
        if (!err_reg)
        begin
            case (mode_reg)
                msbb_pkg::MODE_PUT,
                msbb_pkg::MODE_GET,
                msbb_pkg::MODE_SKIP: pos_next = pos_reg + count_reg;
                msbb_pkg::MODE_SET:  pos_next = npos_reg;
                default:             pos_next = pos_reg;
            endcase
        end
        rem_out  = (pos_next < limit_bits) ? (limit_bits - pos_next) : 12'd0;
        out_load = (state_reg == ST_OUT) && (!out_valid_reg || !out_stall);
    end

    // sequencer: one byte per cycle in ST_MOD, read and, for put, merged and written back
    always_comb
    begin
        state_next      = state_reg;
        bytes_left_next = bytes_left_reg;
        cur_addr_next   = cur_addr_reg;
        put_win_next    = put_win_reg;
        acc_next        = acc_reg;
        out_valid_next  = out_valid_reg && !out_take;
        mem_raddr       = first_addr;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    cur_addr_next   = first_addr;
                    bytes_left_next = nb_acc;
                    put_win_next    = win_acc;
                    state_next      = access_acc ? ST_MOD : ST_OUT;
                end
            end
            ST_MOD:
            begin
                acc_next        = {acc_reg[WB-9:0], mem_rdata};
                put_win_next    = put_win_reg << 8;
                bytes_left_next = bytes_left_reg - 3'd1;
                if (bytes_left_reg == 3'd1)
                begin
                    mem_raddr  = cur_addr_reg;
                    state_next = ST_OUT;
                end
                else
                begin
                    mem_raddr     = cur_addr_reg + AW'(1);
                    cur_addr_next = cur_addr_reg + AW'(1);
                end
            end
            ST_OUT:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // RAM write: clearing pass, or merge of put bits
    assign mem_we    = clearing_reg ||
                       ((state_reg == ST_MOD) && (mode_reg == msbb_pkg::MODE_PUT));
    assign mem_waddr = clearing_reg ? clr_cnt_reg : cur_addr_reg;
    assign mem_wdata = clearing_reg ? 8'd0 : (mem_rdata | put_win_reg[WB-1 -: 8]);

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            clearing_reg   <= 1'b1;
            clr_cnt_reg    <= '0;
            size_reg       <= 9'd256;
            pos_reg        <= 12'd0;
            out_valid_reg  <= 1'b0;
            bytes_left_reg <= 3'd0;
        end
        else
        begin
            state_reg      <= state_next;
            out_valid_reg  <= out_valid_next;
            bytes_left_reg <= bytes_left_next;
            if (clearing_reg)
            begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == LAST_ADDR)
                begin
                    clearing_reg <= 1'b0;
                end
            end
            if (psel && penable && pwrite && pready && (paddr[2] == msbb_pkg::REG_SIZE_BYTES))
            begin
                size_reg <= pwdata[8:0];
            end
            if (out_load)
            begin
                pos_reg <= pos_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cur_addr_reg <= cur_addr_next;
        put_win_reg  <= put_win_next;
        acc_reg      <= acc_next;
        if (in_accept)
        begin
            mode_reg   <= mode;
            count_reg  <= bit_count;
            npos_reg   <= new_position;
            err_reg    <= err_acc;
            access_reg <= access_acc;
            tail_reg   <= tail_acc;
        end
        if (out_load)
        begin
            rv_reg      <= rv_out;
            res_pos_reg <= pos_next;
            rem_reg     <= rem_out;
            res_err_reg <= err_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign read_value     = rv_reg;
    assign position       = res_pos_reg;
    assign remaining_bits = rem_reg;
    assign error          = res_err_reg;

    // checks
    a_stall_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clearing_reg |-> in_stall)
        else $error("word accepted during clearing pass");

    a_write_source: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (clearing_reg || ((state_reg == ST_MOD) && access_reg)))
        else $error("RAM written outside clearing or put");

    a_span_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MOD) |-> ((bytes_left_reg != 3'd0) && (bytes_left_reg <= 3'd5)))
        else $error("byte span out of range");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && res_err_reg) |-> (rv_reg == 32'd0))
        else $error("refused word carries read bits");

    a_pos_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_OUT) |=> $stable(pos_reg))
        else $error("position moved outside result stage");

endmodule

// ===== hw/rtl/msbb_ram.sv =====
// msbb_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module msbb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== tb/tb_top.sv =====
// tb_top: self-checking testbench for msb_first_bit_buffer_unit.
// Drives words on the valid/stall input, predicts each result and compares it field by field.
// Depends on msbb_pkg and the msb_first_bit_buffer_unit RTL.
module tb_top;

    localparam int STORE_BYTES = 256;
    // modes past set position are refused by the block
    localparam logic [2:0] MODE_UNDEF_LO = 3'd5;
    localparam logic [2:0] MODE_UNDEF_HI = 3'd7;
    localparam logic [2:0] SIZE_ADDR = {msbb_pkg::REG_SIZE_BYTES, 2'b00};
    localparam int MAX_REPORTS = 100;
    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        logic [2:0]  mode;
        logic [11:0] count;
        logic [31:0] value;
        logic [11:0] npos;
    } word_t;

    typedef struct packed {
        logic [31:0] read_value;
        logic [11:0] position;
        logic [11:0] remaining;
        logic        err;
    } result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [2:0]  mode = '0;
    logic [11:0] bit_count = '0;
    logic [31:0] put_value = '0;
    logic [11:0] new_position = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [31:0] read_value;
    logic [11:0] position;
    logic [11:0] remaining_bits;
    logic        error;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // shadow copy of the buffer state
    logic [7:0]  store_img [STORE_BYTES];
    logic [11:0] model_pos = '0;
    logic [8:0]  model_size = 9'd256;

    result_t awaited_results [$];
    int mismatch_count = 0;
    int words_sent = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_req_count = 0;
    int hold_seen = 0;
    int hold_left = 0;

    msb_first_bit_buffer_unit #(
        .STORE_BYTES(STORE_BYTES)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .mode(mode),
        .bit_count(bit_count),
        .put_value(put_value),
        .new_position(new_position),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .read_value(read_value),
        .position(position),
        .remaining_bits(remaining_bits),
        .error(error),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    always #5 clk = ~clk;

    // bits usable under the current size register
    function automatic int store_limit();
        return (model_size > STORE_BYTES) ? STORE_BYTES * 8 : int'(model_size) * 8;
    endfunction

    // apply one word to the shadow state and return the result it produces
    function automatic result_t bitbuf_apply(word_t w);
        result_t r;
        int lim, p, cnt, i, b, sh;
        logic refused;
        r = '0;
        lim = store_limit();
        p = int'(model_pos);
        cnt = int'(w.count);
        refused = 1'b0;
        case (w.mode)
            msbb_pkg::MODE_PUT, msbb_pkg::MODE_GET, msbb_pkg::MODE_SHOW:
            begin
                if (cnt > msbb_pkg::MAX_FIELD_BITS || p > lim || cnt > lim - p)
                    refused = 1'b1;
                else if (w.mode == msbb_pkg::MODE_PUT)
                begin
                    // MSB of the field lands first, bit 7 of each byte first
                    for (i = 0; i < cnt; i++)
                    begin
                        b = ((p + i) >> 3) % STORE_BYTES;
                        sh = 7 - ((p + i) & 7);
                        store_img[b][sh] = store_img[b][sh] | w.value[cnt - 1 - i];
                    end
                    model_pos = model_pos + w.count;
                end
                else
                begin
                    for (i = 0; i < cnt; i++)
                    begin
                        b = ((p + i) >> 3) % STORE_BYTES;
                        sh = 7 - ((p + i) & 7);
                        r.read_value = {r.read_value[30:0], store_img[b][sh]};
                    end
                    if (w.mode == msbb_pkg::MODE_GET)
                        model_pos = model_pos + w.count;
                end
            end
            msbb_pkg::MODE_SKIP: model_pos = model_pos + w.count;
            msbb_pkg::MODE_SET:  model_pos = w.npos;
            default:             refused = 1'b1;
        endcase
        r.position = model_pos;
        r.remaining = (int'(model_pos) < lim) ? 12'(lim - int'(model_pos)) : 12'd0;
        r.err = refused;
        return r;
    endfunction

    task automatic note_mismatch(string what, logic [31:0] got, logic [31:0] want);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("MISMATCH at %0t: %s got 0x%0h, expected 0x%0h", $time, what, got, want);
    endtask

    // offer one word, wait for it to be taken, maybe idle afterwards
    task automatic send_word(logic [2:0] m, logic [11:0] cnt, logic [31:0] val,
                             logic [11:0] np);
        word_t w;
        w = '{mode: m, count: cnt, value: val, npos: np};
        @(negedge clk);
        in_valid <= 1'b1;
        mode <= m;
        bit_count <= cnt;
        put_value <= val;
        new_position <= np;
        do @(posedge clk); while (in_stall);
        awaited_results.push_back(bitbuf_apply(w));
        words_sent++;
        if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat ($urandom_range(0, 5)) @(negedge clk);
        end
    endtask

    task automatic wait_for_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
    endtask

    // write the size register, then read it back
    task automatic set_store_size(logic [8:0] n);
        logic [31:0] rd;
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= SIZE_ADDR;
        pwdata <= {23'd0, n};
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        model_size = n;
        @(negedge clk);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        rd = prdata;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        if (rd[8:0] !== n)
            note_mismatch("size_bytes readback", rd, {23'd0, n});
    endtask

    // move to bit p, either directly or by a skip from zero
    task automatic reposition(int p);
        if ($urandom_range(0, 1))
            send_word(msbb_pkg::MODE_SET, 12'($urandom_range(0, 4095)), $urandom, 12'(p));
        else
        begin
            send_word(msbb_pkg::MODE_SET, 12'($urandom_range(0, 4095)), $urandom, 12'd0);
            send_word(msbb_pkg::MODE_SKIP, 12'(p), $urandom, 12'($urandom_range(0, 4095)));
        end
    endtask

    // mostly put a run of fields and read it back, sometimes noise
    task automatic run_random_burst();
        int lim, p, k, i;
        int widths [6];
        lim = store_limit();
        if ($urandom_range(0, 99) < 25)
        begin
            if ($urandom_range(0, 1))
                send_word(3'($urandom_range(msbb_pkg::MODE_PUT, MODE_UNDEF_HI)),
                          12'($urandom_range(0, 4095)), $urandom,
                          12'($urandom_range(0, 4095)));
            else
                send_word(3'($urandom_range(msbb_pkg::MODE_PUT, msbb_pkg::MODE_SET)),
                          12'($urandom_range(0, 40)), $urandom,
                          12'($urandom_range(0, lim + 16)));
        end
        else
        begin
            k = $urandom_range(1, 6);
            p = $urandom_range(0, lim);
            for (i = 0; i < k; i++)
            begin
                case ($urandom_range(0, 9))
                    0:       widths[i] = msbb_pkg::MAX_FIELD_BITS;
                    1:       widths[i] = 0;
                    2:       widths[i] = 1;
                    default: widths[i] = $urandom_range(1, msbb_pkg::MAX_FIELD_BITS);
                endcase
            end
            reposition(p);
            for (i = 0; i < k; i++)
                send_word(msbb_pkg::MODE_PUT, 12'(widths[i]), $urandom,
                          12'($urandom_range(0, 4095)));
            reposition(p);
            for (i = 0; i < k; i++)
                send_word(($urandom_range(0, 3) == 0) ? msbb_pkg::MODE_SHOW : msbb_pkg::MODE_GET,
                          12'(widths[i]), $urandom, 12'($urandom_range(0, 4095)));
        end
    endtask

    // field extremes and the corner cases at the reset size
    task automatic test_directed();
        logic [2:0] m;
        send_idle_pct = 8;
        recv_idle_pct = 62;
        send_word(msbb_pkg::MODE_GET, 12'd0, 32'h0, 12'd0);
        send_word(msbb_pkg::MODE_PUT, 12'd32, 32'hA5C3_0F96, 12'd0);
        send_word(msbb_pkg::MODE_SET, 12'd0, 32'h0, 12'd0);
        send_word(msbb_pkg::MODE_SHOW, 12'd32, 32'h0, 12'd0);
        send_word(msbb_pkg::MODE_GET, 12'd32, 32'h0, 12'd0);
        // count over the field limit
        send_word(msbb_pkg::MODE_PUT, 12'd33, 32'hFFFF_FFFF, 12'd0);
        send_word(msbb_pkg::MODE_GET, 12'hFFF, 32'h0, 12'd0);
        send_word(msbb_pkg::MODE_SHOW, 12'd33, 32'h0, 12'd0);
        // 32 bits at offset 4 touch five bytes
        send_word(msbb_pkg::MODE_SET, 12'd0, 32'h0, 12'd4);
        send_word(msbb_pkg::MODE_PUT, 12'd32, 32'hFFFF_FFFF, 12'd0);
        send_word(msbb_pkg::MODE_SET, 12'd0, 32'h0, 12'd0);
        send_word(msbb_pkg::MODE_GET, 12'd32, 32'h0, 12'd0);
        send_word(msbb_pkg::MODE_GET, 12'd8, 32'h0, 12'd0);
        // last bit of the store, then one past it
        send_word(msbb_pkg::MODE_SET, 12'd0, 32'h0, 12'd2047);
        send_word(msbb_pkg::MODE_PUT, 12'd1, 32'h1, 12'd0);
        send_word(msbb_pkg::MODE_GET, 12'd1, 32'h0, 12'd0);
        send_word(msbb_pkg::MODE_SHOW, 12'd0, 32'h0, 12'd0);
        // position beyond the end, and wrap on skip
        send_word(msbb_pkg::MODE_SET, 12'd0, 32'h0, 12'hFFF);
        send_word(msbb_pkg::MODE_GET, 12'd0, 32'h0, 12'd0);
        send_word(msbb_pkg::MODE_SKIP, 12'hFFF, 32'h0, 12'd0);
        send_word(msbb_pkg::MODE_SKIP, 12'd1, 32'h0, 12'd0);
        send_word(msbb_pkg::MODE_SKIP, 12'd1, 32'h0, 12'd0);
        send_word(msbb_pkg::MODE_PUT, 12'd0, 32'hFFFF_FFFF, 12'd0);
        for (m = MODE_UNDEF_LO; m != msbb_pkg::MODE_PUT; m++)
            send_word(m, 12'($urandom_range(0, 4095)), $urandom,
                      12'($urandom_range(0, 4095)));
        wait_for_results();
    endtask

    // zero size, one byte, and a size above the store
    task automatic test_size_edges();
        set_store_size(9'd0);
        send_word(msbb_pkg::MODE_GET, 12'd0, 32'h0, 12'd0);
        send_word(msbb_pkg::MODE_GET, 12'd1, 32'h0, 12'd0);
        send_word(msbb_pkg::MODE_PUT, 12'd1, 32'h1, 12'd0);
        send_word(msbb_pkg::MODE_SKIP, 12'd5, 32'h0, 12'd0);
        send_word(msbb_pkg::MODE_SET, 12'd0, 32'h0, 12'd0);
        wait_for_results();
        set_store_size(9'd1);
        send_word(msbb_pkg::MODE_PUT, 12'd8, 32'h5A, 12'd0);
        send_word(msbb_pkg::MODE_SET, 12'd0, 32'h0, 12'd0);
        send_word(msbb_pkg::MODE_SHOW, 12'd8, 32'h0, 12'd0);
        send_word(msbb_pkg::MODE_GET, 12'd8, 32'h0, 12'd0);
        send_word(msbb_pkg::MODE_GET, 12'd1, 32'h0, 12'd0);
        wait_for_results();
        set_store_size(9'h1FF);
        send_word(msbb_pkg::MODE_SET, 12'd0, 32'h0, 12'd2040);
        send_word(msbb_pkg::MODE_GET, 12'd8, 32'h0, 12'd0);
        send_word(msbb_pkg::MODE_GET, 12'd1, 32'h0, 12'd0);
        send_word(msbb_pkg::MODE_SET, 12'd0, 32'h0, 12'd2048);
        wait_for_results();
        set_store_size(9'd256);
    endtask

    // random traffic in chunks of 100 words, new size before each chunk
    task automatic test_random_traffic(int n_words, int s_pct, int r_pct);
        int target;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        repeat (n_words / 100)
        begin
            wait_for_results();
            case ($urandom_range(0, 5))
                0:       set_store_size(9'd1);
                1:       set_store_size(9'd5);
                2:       set_store_size(9'd256);
                3:       set_store_size(9'h1FF);
                default: set_store_size(9'($urandom_range(1, 300)));
            endcase
            target = words_sent + 100;
            while (words_sent < target)
                run_random_burst();
        end
    endtask

    // receiver holds off long enough to back the block up to its input
    task automatic test_long_stall();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        wait_for_results();
        set_store_size(9'd256);
        @(posedge clk);
        hold_req_count++;
        repeat (8) run_random_burst();
        wait_for_results();
    endtask

    // receiver stall: long hold-off when requested, otherwise random
    always @(negedge clk)
    begin
        if (hold_req_count != hold_seen)
        begin
            hold_seen <= hold_req_count;
            hold_left <= HOLD_CYCLES - 1;
            out_stall <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else
            out_stall <= (recv_idle_pct != 0) && ($urandom_range(0, 99) < recv_idle_pct);
    end

    // compare each taken result with the oldest prediction
    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (awaited_results.size() == 0)
                note_mismatch("result with nothing expected", read_value, 32'h0);
            else
            begin
                want = awaited_results.pop_front();
                if (read_value !== want.read_value)
                    note_mismatch("read_value", read_value, want.read_value);
                if (position !== want.position)
                    note_mismatch("position", 32'(position), 32'(want.position));
                if (remaining_bits !== want.remaining)
                    note_mismatch("remaining_bits", 32'(remaining_bits), 32'(want.remaining));
                if (error !== want.err)
                    note_mismatch("error", 32'(error), 32'(want.err));
            end
        end
    end

    initial
    begin
        foreach (store_img[i])
            store_img[i] = 8'h00;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_size_edges();
        test_random_traffic(500, 8, 62);
        test_long_stall();
        test_random_traffic(500, 62, 8);
        test_random_traffic(500, 0, 0);
        wait_for_results();
        repeat (20) @(posedge clk);
        if (mismatch_count == 0)
            $display("msb_first_bit_buffer_unit test passed");
        else
            $display("msb_first_bit_buffer_unit test failed");
        $finish;
    end

    // watchdog
    initial
    begin
        #5000000;
        $display("msb_first_bit_buffer_unit test failed");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/msbb_pkg.sv
hw/rtl/msbb_ram.sv
hw/rtl/msb_first_bit_buffer_unit.sv
tb/tb_top.sv
